// ===== hw/rtl/x86_page_walk_permission_check_unit_macros.svh =====
// Assertion macros for the page walk permission check unit.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef X86_PAGE_WALK_PERMISSION_CHECK_UNIT_MACROS_SVH
`define X86_PAGE_WALK_PERMISSION_CHECK_UNIT_MACROS_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define PWC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PWC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PWC_ASSERT(label, clk, rst, prop, msg)

`define PWC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/x86pwc_pkg.sv =====
// Shared types and constants for the page walk permission check unit.
// No dependencies; imported by x86_page_walk_permission_check_unit.
package x86pwc_pkg;

   localparam int LOW_PAGES_DEFAULT = 256;
   localparam int PAGE_W            = 20;
   localparam int ADDR_W            = 32;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 20;

   // Request action codes
   localparam logic [1:0] ACT_TRANSLATE = 2'd0;
   localparam logic [1:0] ACT_CHECK     = 2'd1;
   localparam logic [1:0] ACT_MAP_WRITE = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGING   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_BASE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ARCH     = 2'd2;

   // CPU-generation checking rules
   localparam logic [1:0] ARCH_FAST      = 2'd0;
   localparam logic [1:0] ARCH_386_SLOW  = 2'd1;
   localparam logic [1:0] ARCH_486_SLOW  = 2'd2;

   localparam logic [1:0] PRIV_SUPER = 2'd0;
   localparam logic [1:0] PRIV_USER  = 2'd3;

   // Link modes
   localparam logic [1:0] LINK_RW           = 2'd0;
   localparam logic [1:0] LINK_RO           = 2'd1;
   localparam logic [1:0] LINK_USER_RECHECK = 2'd2;
   localparam logic [1:0] LINK_WP_DEFERRED  = 2'd3;

   // Page entry bit positions
   localparam int PTE_P = 0;
   localparam int PTE_W = 1;
   localparam int PTE_U = 2;
   localparam int PTE_A = 5;
   localparam int PTE_D = 6;

   localparam logic [9:0] DIR_INDEX_MASK = 10'h3ff;

   // Page-fault error code pieces
   localparam logic [2:0] FC_WRITE     = 3'h2;
   localparam logic [2:0] FC_USER      = 3'h4;
   localparam logic [2:0] FC_PROT_USER = 3'h5;

   typedef struct packed {
      logic [1:0]        action;
      logic [ADDR_W-1:0] linear_addr;
      logic              is_write;
      logic [1:0]        priv_level;
      logic [ADDR_W-1:0] dir_entry;
      logic [ADDR_W-1:0] table_entry;
      logic [PAGE_W-1:0] map_page;
   } req_type;

   typedef struct packed {
      logic              fault;
      logic [2:0]        fault_code;
      logic [PAGE_W-1:0] phys_frame;
      logic [ADDR_W-1:0] dir_entry_addr;
      logic [ADDR_W-1:0] table_entry_addr;
      logic              dir_entry_write;
      logic [ADDR_W-1:0] dir_entry_new;
      logic              table_entry_write;
      logic [ADDR_W-1:0] table_entry_new;
      logic [1:0]        link_mode;
   } rsp_type;

endpackage

// ===== hw/rtl/x86_page_walk_permission_check_unit.sv =====
// Page walk permission check unit: 32-bit x86 two-level translation of one access.
// Depends on x86pwc_pkg and x86_page_walk_permission_check_unit_macros.svh.
//
// Usage:
//   Request channel (req_*): one access per transfer, carrying the action, the
//   linear address, write flag, privilege level, the directory and table entries
//   already fetched for that address, and the page for a low-page map write.
//   Response channel (rsp_*): exactly one result per request, in request order:
//   fault and error code, physical page, both entry addresses, the accessed/dirty
//   write-backs and the link mode.
//   Config channel (csr_*): index 0 paging enable, 1 directory base page,
//   2 checking rules. Always ready; write only while no request is in flight.
// Timing:
//   A transfer loads the request register and, for a low page, the map read
//   register at the same edge; the checked result then moves to the result
//   register once that register can take it; that register drives rsp_valid.
//   Throughput is one request per cycle while rsp_ready stays high.
// Reset:
//   Clears both pipeline valids and the configuration registers, then runs a
//   clearing pass over all LOW_PAGES entries (256 by default) that writes identity
//   into the map, one entry per cycle; req_ready stays low until the pass is done.
// Stall:
//   When rsp_ready is low the result register holds, the request register fills
//   behind it, and req_ready drops only once both stages are occupied.
`include "x86_page_walk_permission_check_unit_macros.svh"

module x86_page_walk_permission_check_unit #(
   parameter int LOW_PAGES = x86pwc_pkg::LOW_PAGES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [x86pwc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [x86pwc_pkg::CSR_DATA_W-1:0]     csr_data,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_action,
   input  logic [x86pwc_pkg::ADDR_W-1:0]         req_linear_addr,
   input  logic                                  req_is_write,
   input  logic [1:0]                            req_priv_level,
   input  logic [x86pwc_pkg::ADDR_W-1:0]         req_dir_entry,
   input  logic [x86pwc_pkg::ADDR_W-1:0]         req_table_entry,
   input  logic [x86pwc_pkg::PAGE_W-1:0]         req_map_page,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_fault,
   output logic [2:0]                            rsp_fault_code,
   output logic [x86pwc_pkg::PAGE_W-1:0]         rsp_phys_frame,
   output logic [x86pwc_pkg::ADDR_W-1:0]         rsp_dir_entry_addr,
   output logic [x86pwc_pkg::ADDR_W-1:0]         rsp_table_entry_addr,
   output logic                                  rsp_dir_entry_write,
   output logic [x86pwc_pkg::ADDR_W-1:0]         rsp_dir_entry_new,
   output logic                                  rsp_table_entry_write,
   output logic [x86pwc_pkg::ADDR_W-1:0]         rsp_table_entry_new,
   output logic [1:0]                            rsp_link_mode
);
   import x86pwc_pkg::*;

   localparam int IDX_W = (LOW_PAGES > 1) ? $clog2(LOW_PAGES) : 1;
   localparam logic [PAGE_W-1:0] LOW_LIMIT = PAGE_W'(LOW_PAGES);
   localparam logic [IDX_W-1:0]  CLR_LAST  = IDX_W'(LOW_PAGES - 1);

   // Outcome of the permission rules on a full translate
   typedef enum logic [1:0] {
      PC_NONE,
      PC_USER,
      PC_RO,
      PC_FAULT
   } perm_type;

   // Configuration registers
   logic              paging_ff;
   logic [PAGE_W-1:0] dir_base_ff;
   logic [1:0]        arch_ff;

   // Low-page map, filled with identity by the clearing pass after reset
   logic [PAGE_W-1:0] map_mem_ff [LOW_PAGES];
   logic [PAGE_W-1:0] map_rd_ff;
   logic              clr_busy_ff;
   logic [IDX_W-1:0]  clr_idx_ff;

   // Request stage
   logic    a_valid_ff;
   req_type a_req_ff;

   // Result stage
   logic    b_valid_ff;
   rsp_type b_rsp_ff;
   rsp_type b_rsp_in;

   logic              adv_a;
   logic              adv_b;
   logic              req_xfer;
   logic [PAGE_W-1:0] req_page;
   logic              req_low;
   logic [IDX_W-1:0]  req_idx;
   req_type           req_in;

   assign csr_ready = 1'b1;

   // Advance each stage when the one after it can take its contents
   assign adv_b     = !b_valid_ff || rsp_ready;
   assign adv_a     = !a_valid_ff || adv_b;
   assign req_ready = adv_a && !clr_busy_ff;
   assign req_xfer  = req_valid && req_ready;

   assign req_page = req_linear_addr[ADDR_W-1:12];
   assign req_low  = req_page < LOW_LIMIT;
   assign req_idx  = req_page[IDX_W-1:0];

   assign req_in = '{action:      req_action,
                     linear_addr: req_linear_addr,
                     is_write:    req_is_write,
                     priv_level:  req_priv_level,
                     dir_entry:   req_dir_entry,
                     table_entry: req_table_entry,
                     map_page:    req_map_page};

   // Configuration writes; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         paging_ff   <= 1'b0;
         dir_base_ff <= '0;
         arch_ff     <= ARCH_FAST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PAGING:   paging_ff   <= csr_data[0];
            CSR_DIR_BASE: dir_base_ff <= csr_data[PAGE_W-1:0];
            CSR_ARCH:     arch_ff     <= csr_data[1:0];
            default:      ;
         endcase
      end
   end

   // Clearing pass: walk every map entry once after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         if (clr_idx_ff == CLR_LAST) begin
            clr_busy_ff <= 1'b0;
         end
         clr_idx_ff <= clr_idx_ff + IDX_W'(1);
      end
   end

   // Map memory: write and read at the request transfer. A map write that is
   // accepted is in place before the next request reads.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         map_mem_ff[clr_idx_ff] <= {{(PAGE_W-IDX_W){1'b0}}, clr_idx_ff};
      end else if (req_xfer && req_low) begin
         if (req_action == ACT_MAP_WRITE) begin
            map_mem_ff[req_idx] <= req_map_page;
         end
         map_rd_ff <= map_mem_ff[req_idx];
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv_a) begin
         a_valid_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         a_req_ff <= req_in;
      end
   end

   // Walk checks and write-back forming
   always_comb begin
      logic [PAGE_W-1:0] lpage;
      logic [ADDR_W-1:0] de;
      logic [ADDR_W-1:0] te;
      logic              wr;
      logic              user;
      logic              slow;
      logic              ue;
      logic              ud;
      logic              udeny;
      logic              wr_prot;
      logic [2:0]        np_code;
      logic [2:0]        prot_code;
      perm_type          pc;

      lpage     = a_req_ff.linear_addr[ADDR_W-1:12];
      de        = a_req_ff.dir_entry;
      te        = a_req_ff.table_entry;
      wr        = a_req_ff.is_write;
      user      = a_req_ff.priv_level == PRIV_USER;
      slow      = (arch_ff == ARCH_386_SLOW) || (arch_ff == ARCH_486_SLOW);
      ue        = te[PTE_U];
      ud        = de[PTE_U];
      udeny     = (arch_ff == ARCH_486_SLOW) ? (!ue || !ud) : (!ue && !ud);
      wr_prot   = !te[PTE_W] || !de[PTE_W];
      np_code   = (wr ? FC_WRITE : 3'b000) |
                  ((a_req_ff.priv_level != PRIV_SUPER) ? FC_USER : 3'b000);
      prot_code = FC_PROT_USER | (wr ? FC_WRITE : 3'b000);
      b_rsp_in  = '0;

      // Full translate permission outcome
      pc = PC_NONE;
      if (udeny) begin
         if (user) begin
            pc = PC_FAULT;
         end else if (slow) begin
            pc = PC_USER;
         end
      end
      if (wr_prot) begin
         if (pc == PC_NONE && slow) begin
            pc = PC_RO;
         end
         if (wr && user) begin
            pc = PC_FAULT;
         end
      end

      priority if (a_req_ff.action != ACT_TRANSLATE && a_req_ff.action != ACT_CHECK) begin
         // map write and the unused code give an all-zero result
         b_rsp_in = '0;
      end else if (!paging_ff) begin
         b_rsp_in.phys_frame = (lpage < LOW_LIMIT) ? map_rd_ff : lpage;
      end else begin
         b_rsp_in.dir_entry_addr = {dir_base_ff, 12'h000} +
                                   {20'h00000, lpage[19:10] & DIR_INDEX_MASK, 2'b00};
         priority if (!de[PTE_P]) begin
            b_rsp_in.fault      = 1'b1;
            b_rsp_in.fault_code = np_code;
         end else begin
            b_rsp_in.table_entry_addr = {de[ADDR_W-1:12], 12'h000} +
                                        {20'h00000, lpage[9:0], 2'b00};
            priority if (!te[PTE_P]) begin
               b_rsp_in.fault      = 1'b1;
               b_rsp_in.fault_code = np_code;
            end else if (a_req_ff.action == ACT_CHECK) begin
               if (user && (udeny || (wr && wr_prot))) begin
                  b_rsp_in.fault      = 1'b1;
                  b_rsp_in.fault_code = prot_code;
               end else begin
                  b_rsp_in.phys_frame = te[ADDR_W-1:12];
               end
            end else if (pc == PC_FAULT) begin
               b_rsp_in.fault      = 1'b1;
               b_rsp_in.fault_code = prot_code;
            end else begin
               if (!de[PTE_A]) begin
                  b_rsp_in.dir_entry_write = 1'b1;
                  b_rsp_in.dir_entry_new   = de | (ADDR_W'(1) << PTE_A);
               end
               if (!te[PTE_A] || !te[PTE_D]) begin
                  b_rsp_in.table_entry_write = 1'b1;
                  b_rsp_in.table_entry_new   = te | (ADDR_W'(1) << PTE_A) |
                     ((wr || pc == PC_NONE) ? (ADDR_W'(1) << PTE_D) : ADDR_W'(0));
               end
               b_rsp_in.phys_frame = te[ADDR_W-1:12];
               unique case (pc)
                  PC_NONE:  b_rsp_in.link_mode = LINK_RW;
                  PC_USER:  b_rsp_in.link_mode = LINK_USER_RECHECK;
                  PC_RO:    b_rsp_in.link_mode = wr ? LINK_WP_DEFERRED : LINK_RO;
                  default:  b_rsp_in.link_mode = LINK_RW;
               endcase
            end
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv_b) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_b && a_valid_ff) begin
         b_rsp_ff <= b_rsp_in;
      end
   end

   assign rsp_valid             = b_valid_ff;
   assign rsp_fault             = b_rsp_ff.fault;
   assign rsp_fault_code        = b_rsp_ff.fault_code;
   assign rsp_phys_frame        = b_rsp_ff.phys_frame;
   assign rsp_dir_entry_addr    = b_rsp_ff.dir_entry_addr;
   assign rsp_table_entry_addr  = b_rsp_ff.table_entry_addr;
   assign rsp_dir_entry_write   = b_rsp_ff.dir_entry_write;
   assign rsp_dir_entry_new     = b_rsp_ff.dir_entry_new;
   assign rsp_table_entry_write = b_rsp_ff.table_entry_write;
   assign rsp_table_entry_new   = b_rsp_ff.table_entry_new;
   assign rsp_link_mode         = b_rsp_ff.link_mode;

   // Checks
   `PWC_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !a_valid_ff && !b_valid_ff, "pipeline not empty after reset")
   `PWC_ASSERT(a_xfer_loads, clock, reset, req_xfer |=> a_valid_ff, "accepted request lost")
   `PWC_ASSERT(a_stall_holds, clock, reset, a_valid_ff && !adv_b |=> a_valid_ff && $stable(a_req_ff), "stalled request changed")
   `PWC_ASSERT(a_stage_moves, clock, reset, a_valid_ff && adv_b |=> b_valid_ff, "request dropped between stages")
   `PWC_ASSERT(a_fault_clean, clock, reset, rsp_valid && rsp_fault |-> !rsp_dir_entry_write && !rsp_table_entry_write && rsp_phys_frame == '0 && rsp_link_mode == LINK_RW, "fault result carries updates")

endmodule
